/* sv/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the syslog timestamp packer: field widths,
// the scan phase encoding and the structures passed between its stages.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned FIELD_W    = 6;
  localparam int unsigned NUM_FIELDS = 5;
  localparam int unsigned TIME_W     = FIELD_W * NUM_FIELDS;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned MLEN_W     = 3;
  localparam int unsigned FLAG_W     = 7;
  localparam int unsigned MONTH_W    = 3 * CHAR_W;
  localparam int unsigned MCODE_W    = 4;

  // Padded widths of the stream data buses.
  localparam int unsigned IN_TDATA_W  = ((CHAR_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((TIME_W + 7) / 8) * 8;

  // Shortest text that the scanner accepts as a complete timestamp.
  localparam logic [POS_W-1:0] MIN_LENGTH = POS_W'(15);
  localparam logic [POS_W-1:0] POS_MAX    = '1;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Separator pattern flags, one per checked offset.
  localparam int unsigned FL_SP3  = 0;
  localparam int unsigned FL_SP5  = 1;
  localparam int unsigned FL_SP6  = 2;
  localparam int unsigned FL_CO8  = 3;
  localparam int unsigned FL_CO9  = 4;
  localparam int unsigned FL_CO11 = 5;
  localparam int unsigned FL_CO12 = 6;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_MONTH,
    PH_SEP,
    PH_NUM,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] packed_time;
    logic              parse_ok;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0]   char_position;
    logic [FLAG_W-1:0]  pattern_flags;
    logic [MONTH_W-1:0] month_chars;
    logic [MLEN_W-1:0]  month_len;
    logic [CNT_W-1:0]   field_count;
    logic [FIELD_W-1:0] field_value;
    logic               digit_run_open;
    logic [TIME_W-1:0]  packed_value;
    phase_t             scan_phase;
    logic               text_ended;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    char_position:  '0,
    pattern_flags:  '0,
    month_chars:    '0,
    month_len:      '0,
    field_count:    '0,
    field_value:    '0,
    digit_run_open: 1'b1,
    packed_value:   '0,
    scan_phase:     PH_LEAD,
    text_ended:     1'b0
  };

endpackage

/* sv/sts_in_reg.sv */
// ----------------------------------------------------------------------------
// sts_in_reg
// Input register: holds one character beat until the scanner takes it.
// ----------------------------------------------------------------------------
module sts_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sts_pkg::item_t in_item,
  output logic           hold_valid,
  input  logic           hold_take,
  output sts_pkg::item_t hold_item
);

  logic           valid_r, valid_nxt;
  sts_pkg::item_t item_r, item_nxt;

  assign in_ready   = !valid_r || hold_take;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

/* sv/sts_scan.sv */
// ----------------------------------------------------------------------------
// sts_scan
// Per-character tokeniser: updates the scan state for each beat and, on the
// beat that ends the string, forms the packed timestamp and clears itself.
// ----------------------------------------------------------------------------
module sts_scan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  sts_pkg::item_t   item,
  input  logic             res_room,
  output logic             item_take,
  output logic             res_valid,
  output sts_pkg::result_t res
);

  localparam logic [sts_pkg::MONTH_W-1:0] MONTH_NAMES [12] = '{
    24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
    24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
  };

  sts_pkg::scan_state_t st_r, st_nxt;
  sts_pkg::scan_state_t st_step;
  logic                 form_two, form_one, ok;

  function automatic logic [sts_pkg::MCODE_W-1:0] month_code(
    input logic [sts_pkg::MONTH_W-1:0] chars
  );
    logic [sts_pkg::MCODE_W-1:0] m;
    m = '0;
    for (int i = 0; i < 12; i++) begin
      if (chars == MONTH_NAMES[i]) begin
        m = sts_pkg::MCODE_W'(i + 1);
      end
    end
    return m;
  endfunction

  function automatic sts_pkg::scan_state_t end_token(input sts_pkg::scan_state_t s);
    sts_pkg::scan_state_t        t;
    logic [sts_pkg::MCODE_W-1:0] m;
    logic [sts_pkg::CNT_W-1:0]   cnt;
    t   = s;
    m   = month_code(s.month_chars);
    cnt = s.field_count + 1'b1;
    case (s.scan_phase)
      sts_pkg::PH_MONTH: begin
        if (s.month_len == sts_pkg::MLEN_W'(3) && m != '0) begin
          t.packed_value = {sts_pkg::FIELD_W'(m), {(sts_pkg::TIME_W - sts_pkg::FIELD_W){1'b0}}};
          t.field_count  = sts_pkg::CNT_W'(1);
          t.scan_phase   = sts_pkg::PH_SEP;
        end else begin
          t.scan_phase = sts_pkg::PH_FAIL;
        end
      end
      sts_pkg::PH_NUM: begin
        t.field_count = cnt;
        case (cnt)
          3'd2: t.packed_value[4*sts_pkg::FIELD_W-1 -: sts_pkg::FIELD_W] = s.field_value;
          3'd3: t.packed_value[3*sts_pkg::FIELD_W-1 -: sts_pkg::FIELD_W] = s.field_value;
          3'd4: t.packed_value[2*sts_pkg::FIELD_W-1 -: sts_pkg::FIELD_W] = s.field_value;
          3'd5: t.packed_value[sts_pkg::FIELD_W-1 -: sts_pkg::FIELD_W]   = s.field_value;
          default: ;
        endcase
        t.scan_phase = (cnt >= sts_pkg::CNT_W'(sts_pkg::NUM_FIELDS)) ?
                       sts_pkg::PH_DONE : sts_pkg::PH_SEP;
      end
      default: ;
    endcase
    return t;
  endfunction

  // Fold one digit into the running value; anything else closes the run.
  function automatic sts_pkg::scan_state_t take_digit(
    input sts_pkg::scan_state_t      s,
    input logic [sts_pkg::CHAR_W-1:0] c
  );
    sts_pkg::scan_state_t        t;
    logic [sts_pkg::CHAR_W-1:0]  d;
    t = s;
    d = c - sts_pkg::CHAR_ZERO;
    if (s.digit_run_open && c >= sts_pkg::CHAR_ZERO && c <= sts_pkg::CHAR_NINE) begin
      t.field_value = (s.field_value << 3) + (s.field_value << 1) + d[sts_pkg::FIELD_W-1:0];
    end else begin
      t.digit_run_open = 1'b0;
    end
    return t;
  endfunction

  function automatic sts_pkg::scan_state_t feed(
    input sts_pkg::scan_state_t       s,
    input logic [sts_pkg::CHAR_W-1:0] c
  );
    sts_pkg::scan_state_t t;
    logic                 sep;
    t   = s;
    sep = (c == sts_pkg::CHAR_SPACE) || (c == sts_pkg::CHAR_COLON);
    case (s.scan_phase)
      sts_pkg::PH_LEAD: begin
        if (!sep) begin
          t.scan_phase  = sts_pkg::PH_MONTH;
          t.month_chars = sts_pkg::MONTH_W'(c);
          t.month_len   = sts_pkg::MLEN_W'(1);
        end
      end
      sts_pkg::PH_MONTH: begin
        if (sep) begin
          t = end_token(s);
        end else begin
          if (s.month_len < sts_pkg::MLEN_W'(3)) begin
            t.month_chars = {s.month_chars[sts_pkg::MONTH_W-sts_pkg::CHAR_W-1:0], c};
          end
          if (s.month_len < sts_pkg::MLEN_W'(4)) begin
            t.month_len = s.month_len + 1'b1;
          end
        end
      end
      sts_pkg::PH_SEP: begin
        if (!sep) begin
          t.scan_phase     = sts_pkg::PH_NUM;
          t.field_value    = '0;
          t.digit_run_open = 1'b1;
          t = take_digit(t, c);
        end
      end
      sts_pkg::PH_NUM: begin
        if (sep) begin
          t = end_token(s);
        end else begin
          t = take_digit(s, c);
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic logic [sts_pkg::FLAG_W-1:0] mark_pattern(
    input logic [sts_pkg::FLAG_W-1:0] f,
    input logic [sts_pkg::POS_W-1:0]  pos,
    input logic [sts_pkg::CHAR_W-1:0] c
  );
    logic [sts_pkg::FLAG_W-1:0] g;
    g = f;
    if (c == sts_pkg::CHAR_SPACE) begin
      if (pos == sts_pkg::POS_W'(3)) g[sts_pkg::FL_SP3] = 1'b1;
      if (pos == sts_pkg::POS_W'(5)) g[sts_pkg::FL_SP5] = 1'b1;
      if (pos == sts_pkg::POS_W'(6)) g[sts_pkg::FL_SP6] = 1'b1;
    end else if (c == sts_pkg::CHAR_COLON) begin
      if (pos == sts_pkg::POS_W'(8))  g[sts_pkg::FL_CO8]  = 1'b1;
      if (pos == sts_pkg::POS_W'(9))  g[sts_pkg::FL_CO9]  = 1'b1;
      if (pos == sts_pkg::POS_W'(11)) g[sts_pkg::FL_CO11] = 1'b1;
      if (pos == sts_pkg::POS_W'(12)) g[sts_pkg::FL_CO12] = 1'b1;
    end
    return g;
  endfunction

  // A last beat may only move on when the result register can take it.
  assign item_take = item_valid && (!item.is_last || res_room);
  assign res_valid = item_take && item.is_last;

  always_comb begin
    st_step = st_r;
    if (!st_r.text_ended) begin
      if (item.char_code == sts_pkg::CHAR_NUL) begin
        st_step            = end_token(st_r);
        st_step.text_ended = 1'b1;
      end else begin
        st_step.pattern_flags = mark_pattern(st_r.pattern_flags, st_r.char_position,
                                             item.char_code);
        if (st_r.char_position != sts_pkg::POS_MAX) begin
          st_step.char_position = st_r.char_position + 1'b1;
        end
        st_step = feed(st_step, item.char_code);
      end
    end
    if (item.is_last && !st_step.text_ended) begin
      st_step = end_token(st_step);
    end

    // Two-digit day form: spaces at 3 and 6, colons at 9 and 12.
    form_two = st_step.pattern_flags[sts_pkg::FL_SP3] && st_step.pattern_flags[sts_pkg::FL_SP6]
            && st_step.pattern_flags[sts_pkg::FL_CO9] && st_step.pattern_flags[sts_pkg::FL_CO12];
    // One-digit day form: spaces at 3 and 5, colons at 8 and 11.
    form_one = st_step.pattern_flags[sts_pkg::FL_SP3] && st_step.pattern_flags[sts_pkg::FL_SP5]
            && st_step.pattern_flags[sts_pkg::FL_CO8] && st_step.pattern_flags[sts_pkg::FL_CO11];
    ok = (st_step.char_position >= sts_pkg::MIN_LENGTH) && (form_two || form_one)
      && (st_step.scan_phase == sts_pkg::PH_DONE)
      && (st_step.field_count == sts_pkg::CNT_W'(sts_pkg::NUM_FIELDS));

    res.packed_time = ok ? st_step.packed_value : '0;
    res.parse_ok    = ok;

    st_nxt = st_r;
    if (item_take) begin
      st_nxt = item.is_last ? sts_pkg::SCAN_RESET : st_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sts_pkg::SCAN_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

/* sv/sts_out_reg.sv */
// ----------------------------------------------------------------------------
// sts_out_reg
// Result register: holds one packed timestamp until the sink takes it.
// ----------------------------------------------------------------------------
module sts_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  sts_pkg::result_t res,
  output logic             res_room,
  output logic             out_valid,
  input  logic             out_ready,
  output sts_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  sts_pkg::result_t res_r, res_nxt;

  assign res_room  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_room) begin
      valid_nxt = res_valid;
      if (res_valid) begin
        res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

endmodule

/* sv/syslog_timestamp_packer.sv */
// ----------------------------------------------------------------------------
// syslog_timestamp_packer
// Parses a "Mmm dd hh:mm:ss" text line, one character per beat, and gives
// the packed month, day, hour, minute and second on the beat marked last.
//
//   Channel  Direction  Beat contents
//   in_      sink       tdata[7:0] character, tlast ends the string
//   out_     source     tdata[29:0] packed time, tuser parse flag
//
// One character beat is taken every cycle while no last beat waits for room
// in the result register; the scan state is updated in a single step between
// the input register and the result register.
// Back-pressure on out_ stalls only the last beat of the next string;
// other characters keep flowing while a result waits.
// Reset is synchronous and clears the scan state and both valid flags.
// ----------------------------------------------------------------------------
module syslog_timestamp_packer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sts_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] char_code
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sts_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [29:0] packed_time
  output logic                                out_tuser,  // [0] parse_ok
  output logic                                out_tlast
);

  sts_pkg::item_t   in_item, hold_item;
  sts_pkg::result_t res, out_res;
  logic             hold_valid, hold_take, res_valid, res_room;

  assign in_item.char_code = in_tdata[sts_pkg::CHAR_W-1:0];
  assign in_item.is_last   = in_tlast;

  sts_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_item  (hold_item)
  );

  sts_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (hold_valid),
    .item       (hold_item),
    .res_room   (res_room),
    .item_take  (hold_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  sts_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = sts_pkg::OUT_TDATA_W'(out_res.packed_time);
  assign out_tuser = out_res.parse_ok;
  // Every result is a complete record of its own.
  assign out_tlast = 1'b1;

endmodule

/* sv/sts_checker.sv */
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the syslog timestamp packer, bound to the top level.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sts_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  localparam int unsigned MSB = sts_pkg::TIME_W - 1;
  localparam int unsigned LSB = sts_pkg::TIME_W - sts_pkg::FIELD_W;

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed parse gave a non-zero time");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[MSB:LSB] != '0 && out_tdata[MSB:LSB] <= sts_pkg::FIELD_W'(12))
    else $error("accepted time has an impossible month");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[sts_pkg::OUT_TDATA_W-1:sts_pkg::TIME_W] == '0)
    else $error("padding bits of the result are set");

endmodule

bind syslog_timestamp_packer sts_checker u_sts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
